>>> src/voc_pkg.sv
// Shared constants, codes and transaction types for the voxel occupancy grid.
// No dependencies; used by every module under src.
`default_nettype none

package voc_pkg;

  // Built grid size per axis, and everything that follows from it.
  localparam int unsigned MAX_DEPTH = 64;
  localparam int unsigned IDX_W     = $clog2(MAX_DEPTH);
  localparam int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int unsigned ROWS      = MAX_DEPTH * MAX_DEPTH;
  localparam int unsigned ROW_W     = $clog2(ROWS);

  // Front-to-back queue; depth must be a power of two (pointers wrap).
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SCALE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH = CFG_IDX_W'(1);
  localparam logic [31:0] CELL_SCALE_RESET = 32'd65536;
  localparam logic [6:0]  GRID_DEPTH_RESET = 7'd64;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_QUERY  = 1'b1
  } action_e;

  typedef struct packed {
    logic [31:0] cell_scale;
    logic [6:0]  grid_depth;
  } cfg_t;

  // One classified item, front to back.
  typedef struct packed {
    logic                is_insert;
    logic                in_bounds;
    logic signed [15:0]  cell_x;
    logic signed [15:0]  cell_y;
    logic signed [15:0]  cell_z;
    logic [ROW_W-1:0]    row;
    logic [IDX_W-1:0]    col;
  } entry_t;

  typedef struct packed {
    logic               in_bounds;
    logic               occupied;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic signed [15:0] cell_z;
  } result_t;

endpackage

`default_nettype wire

>>> src/voc_front.sv
// Front end: accepts items, scales points to cell indices, bounds-checks them.
// Depends on voc_pkg.
`default_nettype none

module voc_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire voc_pkg::cfg_t      cfg_i,
  input  wire logic               hold_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               in_action_i,
  input  wire logic signed [31:0] in_point_x_i,
  input  wire logic signed [31:0] in_point_y_i,
  input  wire logic signed [31:0] in_point_z_i,
  input  wire logic signed [15:0] in_query_x_i,
  input  wire logic signed [15:0] in_query_y_i,
  input  wire logic signed [15:0] in_query_z_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output voc_pkg::entry_t         entry_o
);
  import voc_pkg::*;

  typedef struct packed {
    logic               ok;
    logic signed [15:0] coord;
    logic [IDX_W-1:0]   idx;
  } lane_t;

  // Truncated magnitude q = |p| * scale >> 32, sign restored.
  function automatic lane_t ins_lane(logic neg, logic [31:0] q, logic [DEPTH_W-1:0] depth);
    lane_t r;
    r.ok = (!neg || (q == 32'd0)) && (q < 32'(depth));
    if (q >= 32'd32768) begin
      r.coord = neg ? 16'sh8000 : 16'sh7fff;
    end else begin
      r.coord = neg ? (~q[15:0] + 16'd1) : q[15:0];
    end
    r.idx = q[IDX_W-1:0];
    return r;
  endfunction

  function automatic lane_t qry_lane(logic [15:0] v, logic [DEPTH_W-1:0] depth);
    lane_t r;
    r.ok    = !v[15] && (v < 16'(depth));
    r.coord = v;
    r.idx   = v[IDX_W-1:0];
    return r;
  endfunction

  logic                   adv;
  logic                   s1_valid_q, s1_valid_d;
  logic                   s1_query_q;
  logic [2:0]             s1_neg_q;
  logic [2:0][31:0]       s1_mag_q, s1_mag_d;
  logic [2:0][15:0]       s1_qidx_q;
  logic                   s2_valid_q;
  logic                   s2_query_q;
  logic [2:0]             s2_neg_q;
  logic [2:0][31:0]       s2_hi_q, s2_hi_d;
  logic [2:0][15:0]       s2_qidx_q;
  logic [2:0][31:0]       pt;
  logic [2:0][63:0]       prod;
  logic [DEPTH_W-1:0]     depth_eff;
  lane_t [2:0]            lane;

  assign adv        = !s2_valid_q || !full_i;
  assign in_ready_o = adv && !hold_i;
  assign s1_valid_d = in_valid_i && in_ready_o;
  assign push_o     = s2_valid_q && !full_i;
  assign pt         = {in_point_z_i, in_point_y_i, in_point_x_i};

  assign depth_eff = (32'(cfg_i.grid_depth) > MAX_DEPTH) ? DEPTH_W'(MAX_DEPTH)
                                                         : DEPTH_W'(cfg_i.grid_depth);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_mag_d[i] = pt[i][31] ? (~pt[i] + 32'd1) : pt[i];
      prod[i]     = 64'(s1_mag_q[i]) * 64'(cfg_i.cell_scale);
      s2_hi_d[i]  = prod[i][63:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_query_q <= (in_action_i == ACT_QUERY);
      s1_neg_q   <= {in_point_z_i[31], in_point_y_i[31], in_point_x_i[31]};
      s1_mag_q   <= s1_mag_d;
      s1_qidx_q  <= {in_query_z_i, in_query_y_i, in_query_x_i};
      s2_query_q <= s1_query_q;
      s2_neg_q   <= s1_neg_q;
      s2_hi_q    <= s2_hi_d;
      s2_qidx_q  <= s1_qidx_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lane[i] = s2_query_q ? qry_lane(s2_qidx_q[i], depth_eff)
                           : ins_lane(s2_neg_q[i], s2_hi_q[i], depth_eff);
    end
    entry_o.is_insert = !s2_query_q;
    entry_o.in_bounds = lane[0].ok && lane[1].ok && lane[2].ok;
    entry_o.cell_x    = lane[0].coord;
    entry_o.cell_y    = lane[1].coord;
    entry_o.cell_z    = lane[2].coord;
    entry_o.row       = ROW_W'(ROW_W'(lane[0].idx) * ROW_W'(MAX_DEPTH)) + ROW_W'(lane[1].idx);
    entry_o.col       = lane[2].idx;
  end

endmodule

`default_nettype wire

>>> src/voc_fifo.sv
// Short queue of classified items between front and back end.
// Depends on voc_pkg.
`default_nettype none

module voc_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire voc_pkg::entry_t  entry_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output voc_pkg::entry_t       entry_o,
  output logic                  empty_o
);
  import voc_pkg::*;

  entry_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= entry_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

>>> src/voc_back.sv
// Back end: clearing sweep, occupancy row read-modify-write, result register.
// Depends on voc_pkg.
`default_nettype none

module voc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  wire voc_pkg::entry_t  entry_i,
  output logic                  pop_o,
  output logic                  clearing_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output voc_pkg::result_t      result_o
);
  import voc_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_READ  = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic [ROW_W-1:0]        clr_cnt_q;
  entry_t                  cur_q;
  logic [MAX_DEPTH-1:0]    occ_mem [ROWS];
  logic [MAX_DEPTH-1:0]    rd_row_q;
  logic [MAX_DEPTH-1:0]    upd_row;
  logic                    mem_we;
  logic [ROW_W-1:0]        mem_waddr;
  logic [MAX_DEPTH-1:0]    mem_wdata;
  logic                    fire;
  logic                    clr_last;
  logic                    out_valid_q;
  result_t                 out_q, out_d;

  assign clearing_o  = (state_q == ST_CLEAR);
  assign pop_o       = (state_q == ST_READ) && !empty_i;
  assign fire        = (state_q == ST_WRITE) && (!out_valid_q || out_ready_i);
  assign clr_last    = (clr_cnt_q == ROW_W'(ROWS - 1));
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  always_comb begin
    upd_row             = rd_row_q;
    upd_row[cur_q.col]  = 1'b1;
    out_d.in_bounds     = cur_q.in_bounds;
    out_d.occupied      = cur_q.in_bounds && (rd_row_q[cur_q.col] || cur_q.is_insert);
    out_d.cell_x        = cur_q.cell_x;
    out_d.cell_y        = cur_q.cell_y;
    out_d.cell_z        = cur_q.cell_z;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_q.row;
    mem_wdata = upd_row;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else if (fire && cur_q.is_insert && cur_q.in_bounds) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_READ;
      end
      ST_READ: begin
        if (pop_o) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (fire) state_d = ST_READ;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + ROW_W'(1);
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= entry_i;
    if (fire)  out_q <= out_d;
  end

  // Occupancy memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) occ_mem[mem_waddr] <= mem_wdata;
    if (pop_o)  rd_row_q <= occ_mem[entry_i.row];
  end

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !pop_o) else $error("item taken during clear sweep");
  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_WRITE))
    else $error("result loaded outside update step");
  a_occupied_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.occupied) |-> out_q.in_bounds)
    else $error("occupied reported for out-of-bounds cell");

endmodule

`default_nettype wire

>>> src/voxel_occupancy_grid.sv
// Top level of the voxel occupancy grid: config registers, front end, queue, back end.
// Depends on voc_pkg, voc_front, voc_fifo and voc_back.
`default_nettype none

// Voxel occupancy grid. Holds a MAX_DEPTH^3 bitmap (64^3 as built) stored as
// MAX_DEPTH^2 rows of MAX_DEPTH bits. After reset a clearing sweep writes one
// row per cycle over all MAX_DEPTH^2 = 4096 rows, with s_axis_tready low; config
// writes are taken throughout. An insert (tuser 0) scales each Q16.16
// coordinate by cell_scale, truncates toward zero and sets the cell's bit when
// all indices are inside grid_depth (clamped to MAX_DEPTH). A query (tuser 1)
// reads the bit at the given indices. Every item gives exactly one result.
// Rate: the front end is a two-stage pipeline (magnitude, then the three
// 32x32 scale multipliers) that takes one item per cycle into a 4-entry queue;
// unless its output waits on a full queue or the clear sweep runs; the back end
// reads the occupancy row in one state and writes it back in the next once the
// result register is free, with no overlap between items.
// Configuration must only change while no transaction is in flight.
module voxel_occupancy_grid (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // config write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [voc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [voc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [31:0] point_x, [63:32] point_y, [95:64] point_z,
  // [111:96] query_x, [127:112] query_y, [143:128] query_z
  input  wire logic [143:0]                    s_axis_tdata,
  // [0] action
  input  wire logic                            s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [0] in_bounds, [1] occupied, [17:2] cell_x, [33:18] cell_y,
  // [49:34] cell_z, [55:50] zero
  output logic [55:0]                          m_axis_tdata
);
  import voc_pkg::*;

  cfg_t     cfg_q;
  logic     clearing;
  logic     q_push, q_pop, q_full, q_empty;
  entry_t   q_in, q_out;
  result_t  result;

  // Config writes are always accepted; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_scale <= CELL_SCALE_RESET;
      cfg_q.grid_depth <= GRID_DEPTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_CELL_SCALE: cfg_q.cell_scale <= cfg_data_i[31:0];
        REG_GRID_DEPTH: cfg_q.grid_depth <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Front: classify, held off during the clear sweep.
  voc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .hold_i       (clearing),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_action_i  (s_axis_tuser),
    .in_point_x_i (s_axis_tdata[31:0]),
    .in_point_y_i (s_axis_tdata[63:32]),
    .in_point_z_i (s_axis_tdata[95:64]),
    .in_query_x_i (s_axis_tdata[111:96]),
    .in_query_y_i (s_axis_tdata[127:112]),
    .in_query_z_i (s_axis_tdata[143:128]),
    .full_i       (q_full),
    .push_o       (q_push),
    .entry_o      (q_in)
  );

  voc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .empty_o (q_empty)
  );

  // Back: bitmap update and result register.
  voc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .entry_i     (q_out),
    .pop_o       (q_pop),
    .clearing_o  (clearing),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  assign m_axis_tdata = {6'b0, result.cell_z, result.cell_y, result.cell_x,
                         result.occupied, result.in_bounds};

endmodule

`default_nettype wire
